// File: rtl/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types and constants for the stream find-and-replace block.
// ----------------------------------------------------------------------------
package sfr_pkg;

    // Default sizing handed to the top-level parameters
    localparam int MAX_PATTERN_BYTES_DEF     = 8;
    localparam int MAX_REPLACEMENT_BYTES_DEF = 8;
    localparam int QUEUE_DEPTH_DEF           = 4;

    // Fixed field widths
    localparam int STR_W   = 64;  // pattern / replacement word
    localparam int LEN_W   = 4;   // length registers
    localparam int JOB_IDX = 3;   // byte index within one job word
    localparam int APB_AW  = 5;   // four 64-bit registers at 8-byte spacing
    localparam int APB_DW  = 64;

    // Register indexes (paddr[4:3])
    typedef enum logic [1:0] {
        REG_PATTERN_BYTES     = 2'd0,
        REG_PATTERN_LENGTH    = 2'd1,
        REG_REPLACEMENT_BYTES = 2'd2,
        REG_REPLACEMENT_LEN   = 2'd3
    } reg_idx_t;

    // Input transfer payload
    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } text_in_t;

    // Result transfer payload
    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       last_of_text;
    } result_t;

    // Decoded configuration seen by the datapath
    typedef struct packed {
        logic [STR_W-1:0] pattern;
        logic [LEN_W-1:0] plen;      // effective, 1..max
        logic [STR_W-1:0] repl;
        logic [LEN_W-1:0] rlen;      // effective, 0..max
        logic             plen_wr;   // pattern length written this cycle
    } cfg_t;

    // Work handed from front to back: up to eight bytes and an end flag
    typedef struct packed {
        logic [STR_W-1:0] job_bytes;
        logic [LEN_W-1:0] job_count;
        logic             job_last;
    } job_t;

endpackage

// File: rtl/sfr_regs.sv
// ----------------------------------------------------------------------------
// sfr_regs
// APB register file; clamps the effective lengths to the supported range.
// ----------------------------------------------------------------------------
module sfr_regs import sfr_pkg::*; #(
    parameter int MAX_PATTERN_BYTES     = MAX_PATTERN_BYTES_DEF,
    parameter int MAX_REPLACEMENT_BYTES = MAX_REPLACEMENT_BYTES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    logic [STR_W-1:0] pattern_reg, pattern_next;
    logic [LEN_W-1:0] plen_reg, plen_next;
    logic [STR_W-1:0] repl_reg, repl_next;
    logic [LEN_W-1:0] rlen_reg, rlen_next;
    logic             wr_en;
    reg_idx_t         idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[4:3]);

    // Write decode
    always_comb begin
        pattern_next = pattern_reg;
        plen_next    = plen_reg;
        repl_next    = repl_reg;
        rlen_next    = rlen_reg;
        if (wr_en) begin
            unique case (idx)
                REG_PATTERN_BYTES:     pattern_next = pwdata;
                REG_PATTERN_LENGTH:    plen_next    = pwdata[LEN_W-1:0];
                REG_REPLACEMENT_BYTES: repl_next    = pwdata;
                REG_REPLACEMENT_LEN:   rlen_next    = pwdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_reg <= '0;
            plen_reg    <= LEN_W'(1);
            repl_reg    <= '0;
            rlen_reg    <= '0;
        end else begin
            pattern_reg <= pattern_next;
            plen_reg    <= plen_next;
            repl_reg    <= repl_next;
            rlen_reg    <= rlen_next;
        end
    end

    // Read mux
    always_comb begin
        unique case (idx)
            REG_PATTERN_BYTES:     prdata = pattern_reg;
            REG_PATTERN_LENGTH:    prdata = APB_DW'(plen_reg);
            REG_REPLACEMENT_BYTES: prdata = repl_reg;
            REG_REPLACEMENT_LEN:   prdata = APB_DW'(rlen_reg);
            default:               prdata = '0;
        endcase
    end

    // Effective lengths: zero pattern counts as one, both saturate
    always_comb begin
        cfg.pattern = pattern_reg;
        cfg.repl    = repl_reg;
        cfg.plen_wr = wr_en && (idx == REG_PATTERN_LENGTH);
        if (plen_reg == '0)
            cfg.plen = LEN_W'(1);
        else if (plen_reg > LEN_W'(MAX_PATTERN_BYTES))
            cfg.plen = LEN_W'(MAX_PATTERN_BYTES);
        else
            cfg.plen = plen_reg;
        if (rlen_reg > LEN_W'(MAX_REPLACEMENT_BYTES))
            cfg.rlen = LEN_W'(MAX_REPLACEMENT_BYTES);
        else
            cfg.rlen = rlen_reg;
    end

endmodule

// File: rtl/sfr_front.sv
// ----------------------------------------------------------------------------
// sfr_front
// Accepts text bytes, keeps the undecided window, matches it to the pattern and
// turns each transfer that settles bytes or ends text into a back-end job word.
// ----------------------------------------------------------------------------
module sfr_front import sfr_pkg::*; #(
    parameter int MAX_PATTERN_BYTES = MAX_PATTERN_BYTES_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  text_in_t s_data,
    input  cfg_t     cfg,
    output logic     q_valid,
    input  logic     q_ready,
    output job_t     q_job
);

    localparam int P  = MAX_PATTERN_BYTES;
    localparam int FW = $clog2(P + 1);

    logic [FW-1:0]        fill_reg, fill_next;
    logic [P-1:0][7:0]    win_reg, win_next;
    logic [P-1:0][7:0]    cand;
    logic [STR_W-1:0]     packed_bytes;
    logic [LEN_W-1:0]     fill_ext;
    logic                 full;
    logic                 match;
    logic                 fire;
    logic                 eot;

    assign eot      = s_data.end_of_text;
    assign s_ready  = q_ready;
    assign fire     = s_valid && s_ready;
    assign fill_ext = LEN_W'(fill_reg);
    assign full     = (fill_ext + LEN_W'(1)) == cfg.plen;

    // Window with the new byte placed at the fill position
    always_comb begin
        packed_bytes = '0;
        for (int i = 0; i < P; i++) begin
            cand[i] = (FW'(i) == fill_reg) ? s_data.text_byte : win_reg[i];
            packed_bytes[8*i +: 8] = cand[i];
        end
    end

    // Pattern compare over the effective length
    always_comb begin
        match = 1'b1;
        for (int i = 0; i < P; i++) begin
            if ((LEN_W'(i) < cfg.plen) && (cand[i] != cfg.pattern[8*i +: 8]))
                match = 1'b0;
        end
    end

    // Job word: replacement on a match, else a run of window bytes
    always_comb begin
        q_job.job_last = eot;
        if (full && match) begin
            q_job.job_bytes = cfg.repl;
            q_job.job_count = cfg.rlen;
        end else if (full) begin
            q_job.job_bytes = packed_bytes;
            q_job.job_count = eot ? cfg.plen : LEN_W'(1);
        end else begin
            q_job.job_bytes = packed_bytes;
            q_job.job_count = eot ? (fill_ext + LEN_W'(1)) : '0;
        end
        q_valid = s_valid && ((q_job.job_count != '0) || eot);
    end

    // Window update
    always_comb begin
        win_next  = win_reg;
        fill_next = fill_reg;
        if (fire) begin
            if (full && match) begin
                fill_next = '0;
            end else if (full) begin
                for (int i = 0; i < P - 1; i++)
                    win_next[i] = cand[i + 1];
                fill_next = FW'(cfg.plen - LEN_W'(1));
            end else begin
                win_next  = cand;
                fill_next = FW'(fill_ext + LEN_W'(1));
            end
            if (eot)
                fill_next = '0;
        end
        if (cfg.plen_wr)
            fill_next = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else begin
            fill_reg <= fill_next;
        end
    end

    // Window bytes carry no reset: entries above the fill are never used
    always_ff @(posedge aclk) begin
        win_reg <= win_next;
    end

endmodule

// File: rtl/sfr_queue.sv
// ----------------------------------------------------------------------------
// sfr_queue
// Short job queue between front and back end.
// ----------------------------------------------------------------------------
module sfr_queue import sfr_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  job_t in_job,
    output logic out_valid,
    input  logic out_pop,
    output job_t out_job
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    job_t          slot_reg [QUEUE_DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          push;
    logic          pop;

    assign in_ready  = cnt_reg != CW'(QUEUE_DEPTH);
    assign out_valid = cnt_reg != '0;
    assign out_job   = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_pop && out_valid;

    // Pointer and count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        if (push && !pop)
            cnt_next = cnt_reg + CW'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - CW'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (push)
            slot_reg[wr_ptr_reg] <= in_job;
    end

endmodule

// File: rtl/sfr_back.sv
// ----------------------------------------------------------------------------
// sfr_back
// Unpacks job words into result transfers, one byte per cycle while the receiver
// is ready, through an output register.
// ----------------------------------------------------------------------------
module sfr_back import sfr_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    q_valid,
    input  job_t    q_job,
    output logic    q_pop,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_data
);

    logic [JOB_IDX-1:0] idx_reg, idx_next;
    logic               m_valid_reg, m_valid_next;
    result_t            m_data_reg, m_data_next;
    logic               load;
    logic               final_byte;
    logic               bare;

    assign bare       = q_job.job_count == '0;
    assign final_byte = bare || (LEN_W'(idx_reg) == (q_job.job_count - LEN_W'(1)));
    assign load       = q_valid && (!m_valid_reg || m_ready);
    assign q_pop      = load && final_byte;

    // Next byte of the current job
    always_comb begin
        idx_next     = idx_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (load) begin
            m_valid_next             = 1'b1;
            m_data_next.out_byte     = bare ? 8'd0 : q_job.job_bytes[8*idx_reg +: 8];
            m_data_next.has_byte     = !bare;
            m_data_next.last_of_text = q_job.job_last && final_byte;
            idx_next                 = final_byte ? '0 : idx_reg + JOB_IDX'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// File: rtl/stream_find_replace.sv
// ----------------------------------------------------------------------------
// stream_find_replace
// A result passes through the job queue and the output register after its input
// byte is taken. Throughput: one input byte per cycle while each produces at most
// one result and the job queue has room; the back end emits one result per cycle
// while the receiver is ready, so a byte that yields more than one result (up to
// eight) holds the output longer; the job queue absorbs it.
// Reset (aresetn low, synchronous) empties window and queue and restores the
// register defaults: pattern length one, replacement length zero.
// ----------------------------------------------------------------------------
module stream_find_replace import sfr_pkg::*; #(
    parameter int MAX_PATTERN_BYTES     = MAX_PATTERN_BYTES_DEF,
    parameter int MAX_REPLACEMENT_BYTES = MAX_REPLACEMENT_BYTES_DEF,
    parameter int QUEUE_DEPTH           = QUEUE_DEPTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    // Configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    // Text in
    input  logic              s_valid,
    output logic              s_ready,
    input  text_in_t          s_data,
    // Text out
    output logic              m_valid,
    input  logic              m_ready,
    output result_t           m_data
);

    cfg_t cfg;
    logic fq_valid, fq_ready;
    job_t fq_job;
    logic qb_valid, qb_pop;
    job_t qb_job;

    // Register file
    sfr_regs #(
        .MAX_PATTERN_BYTES     (MAX_PATTERN_BYTES),
        .MAX_REPLACEMENT_BYTES (MAX_REPLACEMENT_BYTES)
    ) u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Window and match
    sfr_front #(
        .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .cfg     (cfg),
        .q_valid (fq_valid),
        .q_ready (fq_ready),
        .q_job   (fq_job)
    );

    // Job queue
    sfr_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_job    (fq_job),
        .out_valid (qb_valid),
        .out_pop   (qb_pop),
        .out_job   (qb_job)
    );

    // Result emission
    sfr_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (qb_valid),
        .q_job   (qb_job),
        .q_pop   (qb_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for stream_find_replace. A shadow predictor tracks
// the pattern window and queues the expected output transfers for each text
// byte taken. A checker compares every output transfer field by field. The
// bench runs directed cases first: reset defaults, full-width patterns,
// length saturation and a pattern length change mid-text. It then sends a
// back-pressure burst and random texts built around the pattern under
// several register settings, with random idling on both channels.
// ----------------------------------------------------------------------------
module testbench;
    import sfr_pkg::*;

    localparam int          DRAIN_CYCLES   = 8;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          PHASE_ITEMS    = 24;
    localparam int          RANDOM_PHASES  = 10;
    localparam logic [7:0]  ALPHA_BASE     = 8'h61;

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    logic              s_valid;
    logic              s_ready;
    text_in_t          s_data;
    logic              m_valid;
    logic              m_ready;
    result_t           m_data;

    // Shadow registers and window, as the block holds them after reset
    logic [63:0] pat_word    = '0;
    logic [3:0]  pat_len_reg = 4'd1;
    logic [63:0] rep_word    = '0;
    logic [3:0]  rep_len_reg = 4'd0;
    logic [7:0]  win_bytes [8] = '{default: 8'h00};
    int unsigned win_fill    = 0;

    result_t     pending_output [$];
    int          errors       = 0;
    int          stall_cycles = 0;
    bit          source_idle;
    bit          sink_idle;
    int unsigned sink_hold;

    stream_find_replace uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #2 aclk = ~aclk;

    // Effective pattern length: zero reads as one, saturates at eight
    function automatic int unsigned eff_pattern_length();
        if (pat_len_reg == 4'd0) return 1;
        if (pat_len_reg > 4'd8) return 8;
        return pat_len_reg;
    endfunction

    function automatic void push_out(logic [7:0] b, logic has);
        result_t r;
        r.out_byte     = b;
        r.has_byte     = has;
        r.last_of_text = 1'b0;
        pending_output.push_back(r);
    endfunction

    // One text byte through the window: queue the transfers it causes
    function automatic void find_replace_step(text_in_t item);
        int unsigned plen;
        int unsigned rlen;
        int unsigned n;
        int          i;
        bit          hit;
        result_t     r;
        plen = eff_pattern_length();
        rlen = (rep_len_reg > 4'd8) ? 8 : rep_len_reg;
        n    = 0;
        if (win_fill >= plen) win_fill = 0;
        win_bytes[win_fill] = item.text_byte;
        win_fill++;
        if (win_fill == plen) begin
            hit = 1'b1;
            for (i = 0; i < plen; i++)
                if (win_bytes[i] != pat_word[8*i +: 8]) hit = 1'b0;
            if (hit) begin
                for (i = 0; i < rlen; i++) push_out(rep_word[8*i +: 8], 1'b1);
                n        = rlen;
                win_fill = 0;
            end else begin
                push_out(win_bytes[0], 1'b1);
                n = 1;
                for (i = 1; i < 8; i++) win_bytes[i-1] = win_bytes[i];
                win_fill--;
            end
        end
        // End of text: flush the tail, mark the final transfer
        if (item.end_of_text) begin
            for (i = 0; i < win_fill; i++) push_out(win_bytes[i], 1'b1);
            n        = n + win_fill;
            win_fill = 0;
            if (n == 0) push_out(8'h00, 1'b0);
            r = pending_output.pop_back();
            r.last_of_text = 1'b1;
            pending_output.push_back(r);
        end
    endfunction

    task automatic report_mismatch(string msg);
        errors++;
        if (errors <= 100) $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    // Register write: setup cycle then access cycle
    task automatic write_register(reg_idx_t idx, logic [63:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_PATTERN_BYTES:     pat_word = value;
            REG_PATTERN_LENGTH: begin
                pat_len_reg = value[3:0];
                win_fill    = 0;
            end
            REG_REPLACEMENT_BYTES: rep_word = value;
            REG_REPLACEMENT_LEN:   rep_len_reg = value[3:0];
            default: ;
        endcase
    endtask

    task automatic configure(logic [63:0] pat, logic [3:0] plen,
                             logic [63:0] rep, logic [3:0] rlen);
        write_register(REG_PATTERN_BYTES, pat);
        write_register(REG_PATTERN_LENGTH, 64'(plen));
        write_register(REG_REPLACEMENT_BYTES, rep);
        write_register(REG_REPLACEMENT_LEN, 64'(rlen));
    endtask

    // Offer one text byte; predict once the transfer is taken
    task automatic send_item(logic [7:0] b, logic last);
        int unsigned gap;
        text_in_t    item;
        item.text_byte   = b;
        item.end_of_text = last;
        @(negedge aclk);
        gap = source_idle ? $urandom_range(0, 14) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        find_replace_step(item);
    endtask

    // Stop offering, wait for every pending transfer, then let the pipe empty
    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_output.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Random text: whole patterns, broken prefixes and noise
    task automatic send_random_text(output int unsigned sent);
        logic [7:0]  text_q [$];
        int unsigned text_len;
        int unsigned plen;
        int unsigned cut;
        int unsigned pick;
        int          i;
        text_len = $urandom_range(1, 24);
        plen     = eff_pattern_length();
        while (text_q.size() < text_len) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                for (i = 0; i < plen; i++) text_q.push_back(pat_word[8*i +: 8]);
            end else if (pick < 55) begin
                cut = (plen > 1) ? $urandom_range(1, plen - 1) : 1;
                for (i = 0; i < cut; i++) text_q.push_back(pat_word[8*i +: 8]);
            end else if (pick < 85) begin
                text_q.push_back(ALPHA_BASE + 8'($urandom_range(0, 2)));
            end else begin
                text_q.push_back(8'($urandom_range(0, 255)));
            end
        end
        while (text_q.size() > text_len) void'(text_q.pop_back());
        foreach (text_q[k]) send_item(text_q[k], k == text_q.size() - 1);
        sent = text_len;
    endtask

    // Defaults after reset: each zero byte deleted, bare end marker
    task automatic test_reset_defaults();
        send_item(8'h00, 1'b0);
        send_item(8'h41, 1'b0);
        send_item(8'h00, 1'b1);
        settle();
    endtask

    // Eight-byte pattern and replacement with extreme byte values
    task automatic test_full_width_pattern();
        logic [63:0] pat;
        int          i;
        pat = 64'h00FF_A55A_0180_7FFE;
        configure(pat, 4'd8, 64'h0011_2233_4455_66FF, 4'd8);
        send_item(8'hFF, 1'b0);
        for (i = 0; i < 8; i++) send_item(pat[8*i +: 8], 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b1);
        settle();
    endtask

    // Zero pattern length reads as one; oversize lengths saturate
    task automatic test_length_saturation();
        configure(64'h5A, 4'd0, 64'h8877_6655_4433_2211, 4'd15);
        send_item(8'h5A, 1'b1);
        settle();
        write_register(REG_PATTERN_LENGTH, 64'd15);
        send_item(8'h5A, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'h00, 1'b1);
        settle();
    endtask

    // Pattern length write mid-text drops the undecided bytes
    task automatic test_length_change_mid_text();
        configure(64'h6463_6261, 4'd4, 64'h5A5A, 4'd2);
        send_item(8'h61, 1'b0);
        send_item(8'h62, 1'b0);
        send_item(8'h63, 1'b0);
        settle();
        write_register(REG_PATTERN_LENGTH, 64'd2);
        send_item(8'h63, 1'b0);
        send_item(8'h61, 1'b0);
        send_item(8'h62, 1'b1);
        settle();
    endtask

    // Receiver holds off while most bytes expand eightfold
    task automatic test_output_backpressure();
        int i;
        configure(64'h2A, 4'd1, {$urandom, $urandom}, 4'd8);
        source_idle = 1'b0;
        sink_idle   = 1'b0;
        sink_hold   = 120;
        for (i = 0; i < 30; i++)
            send_item(($urandom_range(0, 3) != 0) ? 8'h2A : 8'($urandom_range(0, 255)),
                      i == 29);
        settle();
    endtask

    // Random texts under a sequence of register settings
    task automatic test_random_texts();
        int          phase;
        int          i;
        int unsigned sent;
        int unsigned phase_items;
        logic [63:0] pat;
        logic [3:0]  plen;
        logic [3:0]  rlen;
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            for (i = 0; i < 8; i++)
                pat[8*i +: 8] = ($urandom_range(0, 9) < 7) ?
                                ALPHA_BASE + 8'($urandom_range(0, 2)) :
                                8'($urandom_range(0, 255));
            plen = ($urandom_range(0, 6) != 0) ? 4'($urandom_range(1, 8))
                                               : 4'($urandom_range(0, 15));
            rlen = ($urandom_range(0, 6) != 0) ? 4'($urandom_range(0, 8))
                                               : 4'($urandom_range(0, 15));
            case (phase)
                0: begin plen = 4'd1; rlen = 4'd8; end
                1: begin plen = 4'd8; rlen = 4'd0; end
                2: begin plen = 4'd8; rlen = 4'd8; end
                default: ;
            endcase
            configure(pat, plen, {$urandom, $urandom}, rlen);
            source_idle = (phase == 1) ? 1'b0 : 1'($urandom_range(0, 2) != 0);
            sink_idle   = (phase == 1) ? 1'b0 : 1'($urandom_range(0, 2) != 0);
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                send_random_text(sent);
                phase_items += sent;
            end
            settle();
        end
    endtask

    // Receiver: random hold-off per transfer, or a long stall on request
    initial begin : result_sink
        int unsigned wait_cycles;
        m_ready = 1'b0;
        @(negedge aclk);
        forever begin
            if (sink_hold != 0) begin
                wait_cycles = sink_hold;
                sink_hold   = 0;
            end else begin
                wait_cycles = sink_idle ? $urandom_range(0, 14) : 0;
            end
            if (wait_cycles > 0) begin
                m_ready <= 1'b0;
                repeat (wait_cycles) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            @(negedge aclk);
        end
    end

    // Compare each output transfer with the oldest pending one
    always @(posedge aclk) begin : output_check
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_output.size() == 0) begin
                report_mismatch($sformatf("unexpected transfer %h", m_data));
            end else begin
                want = pending_output.pop_front();
                if (m_data.out_byte !== want.out_byte)
                    report_mismatch($sformatf("out_byte %h, want %h",
                                              m_data.out_byte, want.out_byte));
                if (m_data.has_byte !== want.has_byte)
                    report_mismatch($sformatf("has_byte %b, want %b",
                                              m_data.has_byte, want.has_byte));
                if (m_data.last_of_text !== want.last_of_text)
                    report_mismatch($sformatf("last_of_text %b, want %b",
                                              m_data.last_of_text, want.last_of_text));
            end
        end
    end

    // Watchdog: cycles in a row with no transfer on either channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        aresetn     = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        s_valid     = 1'b0;
        s_data      = '0;
        source_idle = 1'b1;
        sink_idle   = 1'b1;
        sink_hold   = 0;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_full_width_pattern();
        test_length_saturation();
        test_length_change_mid_text();
        source_idle = 1'b1;
        sink_idle   = 1'b1;
        test_output_backpressure();
        test_random_texts();
        settle();

        if (errors == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule

// File: stream_find_replace.f
rtl/sfr_pkg.sv
rtl/sfr_regs.sv
rtl/sfr_front.sv
rtl/sfr_queue.sv
rtl/sfr_back.sv
rtl/stream_find_replace.sv
tb/testbench.sv
